// File: hdl/route_table_recursive_lookup_defines.svh
// Assertion macros shared by the route table lookup modules.
`ifndef ROUTE_TABLE_RECURSIVE_LOOKUP_DEFINES_SVH
`define ROUTE_TABLE_RECURSIVE_LOOKUP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RTRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RTRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rtrl_pkg.sv
// Types, codes and microcode program of the route table lookup.
package rtrl_pkg;

    localparam int ADDR_W          = 32;
    localparam int PREFIX_W        = 6;
    localparam int SLOT_IN_W       = 4;
    localparam int ITF_W           = 4;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int MAX_PREFIX      = 32;
    localparam int INTERFACE_COUNT = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOROUTE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOOP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd3;

    // One stored route
    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [PREFIX_W-1:0] prefix;
        logic                is_gw;
        logic [ADDR_W-1:0]   next;
    } rtrl_entry_t;

    // Microcode steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LK_INIT,
        S_READ,
        S_CHECK,
        S_KIND,
        S_GW_TAKE,
        S_SLOT_NEXT,
        S_WRITE,
        S_EMIT_FOUND,
        S_EMIT_NOROUTE,
        S_EMIT_LOOP,
        S_EMIT_DONE
    } rtrl_step_t;

    // Jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_NO_ITEM,
        COND_NOT_LOOKUP,
        COND_MISS,
        COND_DIRECT,
        COND_LAST_PASS,
        COND_LAST_SLOT,
        COND_OUT_BUSY
    } rtrl_cond_t;

    // Result selection
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_FOUND,
        EMIT_NOROUTE,
        EMIT_LOOP,
        EMIT_DONE
    } rtrl_emit_t;

    // Control word of one step
    typedef struct packed {
        rtrl_cond_t cond;
        rtrl_step_t jump;
        rtrl_step_t next;
        logic       take;
        logic       act_init;
        logic       act_scan_clr;
        logic       act_read;
        logic       act_gw;
        logic       act_slot_inc;
        logic       act_write;
        rtrl_emit_t emit;
    } rtrl_cw_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic no_item;
        logic not_lookup;
        logic miss;
        logic direct;
        logic last_pass;
        logic last_slot;
        logic out_busy;
    } rtrl_flags_t;

    // True prefix mask: the top len bits set
    function automatic logic [ADDR_W-1:0] rtrl_mask(input logic [PREFIX_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

    // Microcode program
    function automatic rtrl_cw_t rtrl_ucode(input rtrl_step_t step);
        rtrl_cw_t cw;
        cw = '0;
        cw.cond = COND_NEVER;
        cw.jump = S_IDLE;
        cw.next = S_IDLE;
        cw.emit = EMIT_NONE;
        case (step)
            S_IDLE:
            begin
                cw.take = 1'b1;
                cw.cond = COND_NO_ITEM;
                cw.jump = S_IDLE;
                cw.next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cw.cond = COND_NOT_LOOKUP;
                cw.jump = S_WRITE;
                cw.next = S_LK_INIT;
            end
            S_LK_INIT:
            begin
                cw.act_init     = 1'b1;
                cw.act_scan_clr = 1'b1;
                cw.next         = S_READ;
            end
            S_READ:
            begin
                cw.act_read = 1'b1;
                cw.next     = S_CHECK;
            end
            S_CHECK:
            begin
                cw.cond = COND_MISS;
                cw.jump = S_SLOT_NEXT;
                cw.next = S_KIND;
            end
            S_KIND:
            begin
                cw.cond = COND_DIRECT;
                cw.jump = S_EMIT_FOUND;
                cw.next = S_GW_TAKE;
            end
            S_GW_TAKE:
            begin
                cw.act_gw       = 1'b1;
                cw.act_scan_clr = 1'b1;
                cw.cond         = COND_LAST_PASS;
                cw.jump         = S_EMIT_LOOP;
                cw.next         = S_READ;
            end
            S_SLOT_NEXT:
            begin
                cw.act_slot_inc = 1'b1;
                cw.cond         = COND_LAST_SLOT;
                cw.jump         = S_EMIT_NOROUTE;
                cw.next         = S_READ;
            end
            S_WRITE:
            begin
                cw.act_write = 1'b1;
                cw.next      = S_EMIT_DONE;
            end
            S_EMIT_FOUND:
            begin
                cw.emit = EMIT_FOUND;
                cw.cond = COND_OUT_BUSY;
                cw.jump = S_EMIT_FOUND;
                cw.next = S_IDLE;
            end
            S_EMIT_NOROUTE:
            begin
                cw.emit = EMIT_NOROUTE;
                cw.cond = COND_OUT_BUSY;
                cw.jump = S_EMIT_NOROUTE;
                cw.next = S_IDLE;
            end
            S_EMIT_LOOP:
            begin
                cw.emit = EMIT_LOOP;
                cw.cond = COND_OUT_BUSY;
                cw.jump = S_EMIT_LOOP;
                cw.next = S_IDLE;
            end
            S_EMIT_DONE:
            begin
                cw.emit = EMIT_DONE;
                cw.cond = COND_OUT_BUSY;
                cw.jump = S_EMIT_DONE;
                cw.next = S_IDLE;
            end
            default:
            begin
                cw.next = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// File: hdl/rtrl_if.sv
// Request and response channel interfaces of the route table lookup.
interface rtrl_req_if import rtrl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [SLOT_IN_W-1:0] slot_index;
    logic [ADDR_W-1:0]   address;
    logic [PREFIX_W-1:0] prefix_len;
    logic                via_gateway;
    logic [ADDR_W-1:0]   gateway_in;
    logic [ITF_W-1:0]    interface_in;

    modport source (
        output valid, opcode, slot_index, address, prefix_len, via_gateway,
               gateway_in, interface_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot_index, address, prefix_len, via_gateway,
               gateway_in, interface_in,
        output ready
    );
endinterface

interface rtrl_rsp_if import rtrl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ITF_W-1:0]    interface_out;
    logic [ADDR_W-1:0]   gateway_out;

    modport source (
        output valid, status, interface_out, gateway_out,
        input  ready
    );
    modport sink (
        input  valid, status, interface_out, gateway_out,
        output ready
    );
endinterface

// File: hdl/rtrl_seq.sv
// Microcode sequencer: step counter, program table and jump logic.
`include "route_table_recursive_lookup_defines.svh"

module rtrl_seq
    import rtrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rtrl_flags_t flags,
    output rtrl_cw_t    cw
);

    rtrl_step_t step_reg;
    rtrl_step_t step_next;
    logic       take_jump;

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Fetch the control word and pick the successor
    always_comb
    begin
        cw = rtrl_ucode(step_reg);
        case (cw.cond)
            COND_NEVER:      take_jump = 1'b0;
            COND_NO_ITEM:    take_jump = flags.no_item;
            COND_NOT_LOOKUP: take_jump = flags.not_lookup;
            COND_MISS:       take_jump = flags.miss;
            COND_DIRECT:     take_jump = flags.direct;
            COND_LAST_PASS:  take_jump = flags.last_pass;
            COND_LAST_SLOT:  take_jump = flags.last_slot;
            COND_OUT_BUSY:   take_jump = flags.out_busy;
            default:         take_jump = 1'b0;
        endcase
        step_next = take_jump ? cw.jump : cw.next;
    end

    `RTRL_ASSERT_NEXT(a_emit_returns_idle, (cw.emit != EMIT_NONE) && !flags.out_busy, step_reg == S_IDLE, "result sent but sequencer did not return to idle")
    `RTRL_ASSERT_NOW(a_take_only_idle, cw.take, step_reg == S_IDLE, "item taken outside idle step")
    `RTRL_ASSERT_NEXT(a_last_slot_noroute, (step_reg == S_SLOT_NEXT) && flags.last_slot, step_reg == S_EMIT_NOROUTE, "scan ended without no-route result")

endmodule

// File: hdl/route_table_recursive_lookup.sv
// Top level of the route table with recursive next-hop lookup.
// Write or invalidate: after accept the item passes the dispatch, write and emit-done steps.
// Lookup: init, then read and check per slot scanned, with a slot step on a miss; a gateway
// hit restarts the scan at slot 0, or ends as a loop in pass (valid routes + 2). The route
// memory is read one slot per scan step. One item is in work at a time.
// Reset clears all valid bits, the valid count and the sequencer; no clearing pass.
`include "route_table_recursive_lookup_defines.svh"

module route_table_recursive_lookup
    import rtrl_pkg::*;
#(
    parameter int ROUTE_SLOTS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    rtrl_req_if.sink        req,
    rtrl_rsp_if.source      rsp
);

    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(ROUTE_SLOTS + 1);
    localparam int PASS_W = CNT_W + 1;
    localparam int IDX_W  = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;

    rtrl_cw_t    cw;
    rtrl_flags_t flags;

    // Latched item
    logic [OP_W-1:0]      op_reg;
    logic [SLOT_IN_W-1:0] slot_in_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [PREFIX_W-1:0]  prefix_in_reg;
    logic                 via_gw_reg;
    logic [ADDR_W-1:0]    gw_in_reg;
    logic [ITF_W-1:0]     itf_in_reg;

    // Table state
    logic [ROUTE_SLOTS-1:0] route_valid_reg;
    logic [CNT_W-1:0]       valid_count_reg;
    rtrl_entry_t            route_mem [ROUTE_SLOTS];

    // Scan state
    logic [ADDR_W-1:0] target_reg;
    logic [ADDR_W-1:0] gw_rep_reg;
    logic [PASS_W-1:0] pass_reg;
    logic [SLOT_W-1:0] scan_slot_reg;
    rtrl_entry_t       rd_entry_reg;
    logic              rd_valid_reg;

    // Result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ITF_W-1:0]    out_itf_reg;
    logic [ADDR_W-1:0]   out_gw_reg;

    logic                accept;
    logic                out_busy;
    logic                emit_fire;
    logic [IDX_W-1:0]    slot_wide;
    logic [SLOT_W-1:0]   wr_slot;
    logic                slot_in_range;
    logic                wr_en;
    logic                inval_en;
    rtrl_entry_t         wr_entry;
    logic [ITF_W-1:0]    itf_clamped;
    logic [ADDR_W-1:0]   rd_mask;
    logic                rd_match;
    logic [STATUS_W-1:0] emit_status;
    logic [ITF_W-1:0]    emit_itf;
    logic [ADDR_W-1:0]   emit_gw;

    rtrl_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    assign req.ready = cw.take;
    assign accept    = req.valid && req.ready;
    assign out_busy  = out_valid_reg && !rsp.ready;
    assign emit_fire = (cw.emit != EMIT_NONE) && !out_busy;

    // Decode slot, range and write data
    always_comb
    begin
        slot_wide     = IDX_W'(slot_in_reg);
        wr_slot       = slot_wide[SLOT_W-1:0];
        slot_in_range = ({1'b0, slot_wide} < (IDX_W + 1)'(ROUTE_SLOTS));
        wr_en         = cw.act_write && (op_reg == OP_WRITE) && slot_in_range;
        inval_en      = cw.act_write && (op_reg == OP_INVAL) && slot_in_range
                        && route_valid_reg[wr_slot];
        itf_clamped   = ({5'b0, itf_in_reg} >= 9'(INTERFACE_COUNT))
                        ? ITF_W'(INTERFACE_COUNT - 1) : itf_in_reg;
        wr_entry.base   = addr_reg;
        wr_entry.prefix = (prefix_in_reg > PREFIX_W'(MAX_PREFIX))
                          ? PREFIX_W'(MAX_PREFIX) : prefix_in_reg;
        wr_entry.is_gw  = via_gw_reg;
        wr_entry.next   = via_gw_reg ? gw_in_reg : ADDR_W'(itf_clamped);
    end

    // Compare the slot just read against the current target
    always_comb
    begin
        rd_mask  = rtrl_mask(rd_entry_reg.prefix);
        rd_match = (rd_entry_reg.base & rd_mask) == (target_reg & rd_mask);
        flags.no_item    = !accept;
        flags.not_lookup = (op_reg != OP_LOOKUP);
        flags.miss       = !rd_valid_reg || !rd_match;
        flags.direct     = !rd_entry_reg.is_gw;
        flags.last_pass  = (pass_reg == PASS_W'(valid_count_reg) + PASS_W'(1));
        flags.last_slot  = (scan_slot_reg == SLOT_W'(ROUTE_SLOTS - 1));
        flags.out_busy   = out_busy;
    end

    // Select the result fields
    always_comb
    begin
        case (cw.emit)
            EMIT_FOUND:
            begin
                emit_status = ST_FOUND;
                emit_itf    = rd_entry_reg.next[ITF_W-1:0];
                emit_gw     = gw_rep_reg;
            end
            EMIT_NOROUTE:
            begin
                emit_status = ST_NOROUTE;
                emit_itf    = '0;
                emit_gw     = gw_rep_reg;
            end
            EMIT_LOOP:
            begin
                emit_status = ST_LOOP;
                emit_itf    = '0;
                emit_gw     = gw_rep_reg;
            end
            default:
            begin
                emit_status = ST_DONE;
                emit_itf    = '0;
                emit_gw     = '0;
            end
        endcase
    end

    // Hold the item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= req.opcode;
            slot_in_reg   <= req.slot_index;
            addr_reg      <= req.address;
            prefix_in_reg <= req.prefix_len;
            via_gw_reg    <= req.via_gateway;
            gw_in_reg     <= req.gateway_in;
            itf_in_reg    <= req.interface_in;
        end
    end

    // Route memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_mem[wr_slot] <= wr_entry;
        end
        if (cw.act_read)
        begin
            rd_entry_reg <= route_mem[scan_slot_reg];
        end
    end

    // Update valid bits and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_valid_reg <= '0;
            valid_count_reg <= '0;
        end
        else if (wr_en)
        begin
            route_valid_reg[wr_slot] <= 1'b1;
            if (!route_valid_reg[wr_slot])
            begin
                valid_count_reg <= valid_count_reg + CNT_W'(1);
            end
        end
        else if (inval_en)
        begin
            route_valid_reg[wr_slot] <= 1'b0;
            valid_count_reg          <= valid_count_reg - CNT_W'(1);
        end
    end

    // Advance the scan: target, pass and slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            gw_rep_reg    <= '0;
            pass_reg      <= '0;
            scan_slot_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cw.act_init)
            begin
                target_reg <= addr_reg;
                gw_rep_reg <= addr_reg;
                pass_reg   <= '0;
            end
            if (cw.act_gw)
            begin
                target_reg <= rd_entry_reg.next;
                if (pass_reg == '0)
                begin
                    gw_rep_reg <= rd_entry_reg.next;
                end
                pass_reg <= pass_reg + PASS_W'(1);
            end
            if (cw.act_scan_clr)
            begin
                scan_slot_reg <= '0;
            end
            else if (cw.act_slot_inc)
            begin
                scan_slot_reg <= scan_slot_reg + SLOT_W'(1);
            end
            if (cw.act_read)
            begin
                rd_valid_reg <= route_valid_reg[scan_slot_reg];
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_status_reg <= emit_status;
            out_itf_reg    <= emit_itf;
            out_gw_reg     <= emit_gw;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.interface_out = out_itf_reg;
    assign rsp.gateway_out   = out_gw_reg;

    `RTRL_ASSERT_NOW(a_count_matches, 1'b1, valid_count_reg == CNT_W'($countones(route_valid_reg)), "valid count disagrees with valid bits")
    `RTRL_ASSERT_NOW(a_pass_bounded, cw.act_gw, pass_reg <= PASS_W'(valid_count_reg) + PASS_W'(1), "pass counter ran past loop limit")
    `RTRL_ASSERT_NEXT(a_write_sets_valid, wr_en, route_valid_reg[$past(wr_slot)], "written slot not marked valid")

endmodule

// File: bench/rtrl_lookup_checker.sv
// Route table checker: tracks the table, predicts each result and compares it.
`timescale 1ns / 100ps

module rtrl_lookup_checker
    import rtrl_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    rtrl_req_if  req,
    rtrl_rsp_if  rsp,
    output int   mismatch_count,
    output int   answers_owed
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITF_W-1:0]    itf;
        logic [ADDR_W-1:0]   gw;
    } route_answer_t;

    // Shadow of the route table
    logic                slot_live   [TABLE_SLOTS];
    logic [ADDR_W-1:0]   slot_base   [TABLE_SLOTS];
    logic [PREFIX_W-1:0] slot_plen   [TABLE_SLOTS];
    logic                slot_via_gw [TABLE_SLOTS];
    logic [ADDR_W-1:0]   slot_next   [TABLE_SLOTS];
    int                  live_routes;

    route_answer_t answers_due[$];
    int            fail_total;

    // Network mask with the top len bits set
    function automatic logic [ADDR_W-1:0] net_mask(input logic [PREFIX_W-1:0] len);
        if (len == '0)
            return '0;
        if (len >= MAX_PREFIX)
            return '1;
        return 32'hFFFF_FFFF << (MAX_PREFIX - len);
    endfunction

    // Resolve a destination through the gateway chain
    function automatic route_answer_t resolve_next_hop(input logic [ADDR_W-1:0] dest);
        route_answer_t     res;
        logic [ADDR_W-1:0] target;
        logic [ADDR_W-1:0] first_gw;
        logic              matched;
        int                hop;
        int                s;
        int                passes;
        target   = dest;
        first_gw = dest;
        passes   = live_routes + 2;
        for (hop = 0; hop < passes; hop++)
        begin
            matched = 1'b0;
            for (s = 0; s < TABLE_SLOTS; s++)
            begin
                if (!matched && slot_live[s] &&
                    ((slot_base[s] ^ target) & net_mask(slot_plen[s])) == '0)
                begin
                    matched = 1'b1;
                    if (slot_via_gw[s])
                    begin
                        if (hop == 0)
                            first_gw = slot_next[s];
                        target = slot_next[s];
                    end
                    else
                    begin
                        res.status = ST_FOUND;
                        res.itf    = slot_next[s][ITF_W-1:0];
                        res.gw     = first_gw;
                        return res;
                    end
                end
            end
            if (!matched)
            begin
                res.status = ST_NOROUTE;
                res.itf    = '0;
                res.gw     = first_gw;
                return res;
            end
        end
        res.status = ST_LOOP;
        res.itf    = '0;
        res.gw     = first_gw;
        return res;
    endfunction

    // Apply one request to the shadow table and give its answer
    function automatic route_answer_t apply_request(
        input logic [OP_W-1:0]      op,
        input logic [SLOT_IN_W-1:0] slot,
        input logic [ADDR_W-1:0]    addr,
        input logic [PREFIX_W-1:0]  plen,
        input logic                 via,
        input logic [ADDR_W-1:0]    gw,
        input logic [ITF_W-1:0]     itf
    );
        route_answer_t res;
        res.status = ST_DONE;
        res.itf    = '0;
        res.gw     = '0;
        case (op)
            OP_LOOKUP:
            begin
                res = resolve_next_hop(addr);
            end
            OP_WRITE:
            begin
                if (slot < TABLE_SLOTS)
                begin
                    if (!slot_live[slot])
                        live_routes++;
                    slot_live[slot]   = 1'b1;
                    slot_base[slot]   = addr;
                    slot_plen[slot]   = (plen > MAX_PREFIX) ? PREFIX_W'(MAX_PREFIX) : plen;
                    slot_via_gw[slot] = via;
                    if (via)
                        slot_next[slot] = gw;
                    else if (itf >= INTERFACE_COUNT)
                        slot_next[slot] = INTERFACE_COUNT - 1;
                    else
                        slot_next[slot] = {{(ADDR_W-ITF_W){1'b0}}, itf};
                end
            end
            OP_INVAL:
            begin
                if (slot < TABLE_SLOTS && slot_live[slot])
                begin
                    slot_live[slot] = 1'b0;
                    live_routes--;
                end
            end
            default:
            begin
                // unused opcode leaves the table alone
            end
        endcase
        return res;
    endfunction

    // Compare results first, then log the new request
    always @(posedge clk or negedge rst_n)
    begin
        route_answer_t want;
        int            s;
        if (!rst_n)
        begin
            for (s = 0; s < TABLE_SLOTS; s++)
            begin
                slot_live[s]   = 1'b0;
                slot_base[s]   = '0;
                slot_plen[s]   = '0;
                slot_via_gw[s] = 1'b0;
                slot_next[s]   = '0;
            end
            live_routes = 0;
            answers_due.delete();
            fail_total = 0;
            mismatch_count <= 0;
            answers_owed   <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result status %0d itf %0d gw %h",
                                 $realtime, rsp.status, rsp.interface_out, rsp.gateway_out);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status || rsp.interface_out !== want.itf ||
                        rsp.gateway_out !== want.gw)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"%0t: result mismatch: expected status %0d itf %0d gw %h,",
                                      " got status %0d itf %0d gw %h"},
                                     $realtime, want.status, want.itf, want.gw,
                                     rsp.status, rsp.interface_out, rsp.gateway_out);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                answers_due.push_back(apply_request(req.opcode, req.slot_index, req.address,
                                                    req.prefix_len, req.via_gateway,
                                                    req.gateway_in, req.interface_in));
            end
            mismatch_count <= fail_total;
            answers_owed   <= answers_due.size();
        end
    end

endmodule

// File: bench/tb.sv
// Testbench top: clock, reset, request and response traffic, and the verdict.
`timescale 1ns / 100ps

module tb;
    import rtrl_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 60;

    // Opcode that the block must accept and ignore
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_count;
    int   answers_owed;
    int   cycle_count = 0;
    int   req_calm = 0;
    int   rsp_calm = 0;

    // Stimulus-side memory of written routes, used to aim lookups and gateways
    logic                seen_written [TABLE_SLOTS];
    logic [ADDR_W-1:0]   seen_base    [TABLE_SLOTS];
    logic [PREFIX_W-1:0] seen_plen    [TABLE_SLOTS];

    rtrl_req_if req ();
    rtrl_rsp_if rsp ();

    route_table_recursive_lookup #(
        .ROUTE_SLOTS(TABLE_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    rtrl_lookup_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .answers_owed   (answers_owed)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Address inside a written route's network, or random if the slot is empty
    function automatic logic [ADDR_W-1:0] near_route();
        int s;
        s = $urandom_range(0, TABLE_SLOTS - 1);
        if (!seen_written[s])
            return $urandom;
        return seen_base[s] ^ ($urandom >> seen_plen[s]);
    endfunction

    // Wait a random gap, then hold the item until it is accepted
    task automatic issue(
        input logic [OP_W-1:0]      op,
        input logic [SLOT_IN_W-1:0] slot,
        input logic [ADDR_W-1:0]    addr,
        input logic [PREFIX_W-1:0]  plen,
        input logic                 via,
        input logic [ADDR_W-1:0]    gw,
        input logic [ITF_W-1:0]     itf
    );
        int gap;
        if (req_calm > 0)
        begin
            req_calm--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 39) == 0)
                req_calm = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.opcode       <= op;
        req.slot_index   <= slot;
        req.address      <= addr;
        req.prefix_len   <= plen;
        req.via_gateway  <= via;
        req.gateway_in   <= gw;
        req.interface_in <= itf;
        if (op == OP_WRITE)
        begin
            seen_written[slot] = 1'b1;
            seen_base[slot]    = addr;
            seen_plen[slot]    = plen;
        end
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Response side: stall a random number of cycles before each item
    initial
    begin
        int stall;
        forever
        begin
            if (rsp_calm > 0)
            begin
                rsp_calm--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 4);
                if ($urandom_range(0, 39) == 0)
                    rsp_calm = $urandom_range(10, 30);
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int                  n;
        int                  pick;
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   gw;
        logic [PREFIX_W-1:0] plen;
        logic                via;

        for (n = 0; n < TABLE_SLOTS; n++)
        begin
            seen_written[n] = 1'b0;
            seen_base[n]    = '0;
            seen_plen[n]    = '0;
        end
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.opcode       <= OP_LOOKUP;
        req.slot_index   <= '0;
        req.address      <= '0;
        req.prefix_len   <= '0;
        req.via_gateway  <= 1'b0;
        req.gateway_in   <= '0;
        req.interface_in <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, unused opcode, invalidate of an empty slot
        issue(OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_SPARE,  4'd15, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15);
        issue(OP_INVAL,  4'd5,  32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        // Direct route, then a host gateway route
        issue(OP_WRITE,  4'd0,  32'h0A00_0000, 6'd8,  1'b0, 32'hDEAD_BEEF, 4'd15);
        issue(OP_LOOKUP, 4'd9,  32'h0A12_3456, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_WRITE,  4'd15, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0A00_0001, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'hFFFF_FFFF, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        // Over-long prefix stored as a host route
        issue(OP_WRITE,  4'd3,  32'hC0A8_0001, 6'd63, 1'b0, 32'h0000_0000, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'hC0A8_0001, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'hC0A8_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        // Rewrite as a zero-prefix gateway: a lookup outside 10/8 loops
        issue(OP_WRITE,  4'd3,  32'h0000_0000, 6'd0,  1'b1, 32'hFFFF_FFFF, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'h1234_5678, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        // Direct host route ahead of the loop breaks it
        issue(OP_WRITE,  4'd1,  32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 4'd7);
        issue(OP_LOOKUP, 4'd0,  32'h1234_5678, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        // Two gateway hops: only the first is reported
        issue(OP_WRITE,  4'd2,  32'h0B00_0000, 6'd8,  1'b1, 32'hFFFF_FFFF, 4'd0);
        issue(OP_INVAL,  4'd3,  32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_WRITE,  4'd4,  32'h0C00_0000, 6'd8,  1'b1, 32'h0B00_0001, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'h0C00_0009, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'h5555_5555, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        // Gateway that resolves through itself
        issue(OP_WRITE,  4'd6,  32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'h1234_5678, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_INVAL,  4'd6,  32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0);
        issue(OP_LOOKUP, 4'd0,  32'h0A00_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0);

        // Random mix aimed at the written networks
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                op   = OP_LOOKUP;
                addr = ($urandom_range(0, 9) < 7) ? near_route() : $urandom;
            end
            else if (pick < 75)
            begin
                op   = OP_WRITE;
                addr = ($urandom_range(0, 3) == 0) ? near_route() : $urandom;
            end
            else if (pick < 95)
                op = OP_INVAL;
            else
                op = OP_SPARE;
            if (op != OP_LOOKUP && op != OP_WRITE)
                addr = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 5)
                plen = 6'd0;
            else if (pick < 15)
                plen = PREFIX_W'($urandom_range(33, 63));
            else if (pick < 35)
                plen = PREFIX_W'($urandom_range(1, 7));
            else
                plen = PREFIX_W'($urandom_range(8, 32));

            via = 1'($urandom_range(0, 1));
            gw  = ($urandom_range(0, 9) < 6) ? near_route() : $urandom;
            issue(op, SLOT_IN_W'($urandom_range(0, TABLE_SLOTS - 1)), addr, plen, via, gw,
                  ITF_W'($urandom_range(0, 15)));
        end
        req.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        @(posedge clk);
        while (answers_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
